// ----- rtl/fst_pkg.sv -----
// Shared constants, field widths and controller/datapath interface types for the flow table.
package fst_pkg;

    localparam int MAX_FLOWS_DEFAULT = 128;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int SIZE_W  = 16;
    localparam int TIME_W  = 64;
    localparam int BYTES_W = 64;
    localparam int PKTS_W  = 32;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 8;
    localparam int KEY_W   = ADDR_W + PORT_W;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [PKTS_W-1:0]  packets;
        logic [TIME_W-1:0]  first;
        logic [TIME_W-1:0]  last;
    } fst_rec_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic rec_rd;
        logic commit;
    } fst_cmd_t;

    typedef struct packed {
        logic search_done;
        logic out_free;
    } fst_status_t;

endpackage

// ----- rtl/fst_ctrl.sv -----
// Controller state machine sequencing search, record read and update for each item.
module fst_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fst_pkg::fst_status_t  status,
    output fst_pkg::fst_cmd_t     cmd
);
    import fst_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_RDREC  = 2'd2;
    localparam logic [1:0] ST_WRITE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.scan = 1'b1;
                if (status.search_done) begin
                    state_next = ST_RDREC;
                end
            end
            ST_RDREC: begin
                cmd.rec_rd = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/fst_datapath.sv -----
// Datapath: flow key and record memories, sequential key search, update arithmetic and result register.
module fst_datapath #(
    parameter int MAX_FLOWS = fst_pkg::MAX_FLOWS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fst_pkg::fst_cmd_t            cmd,
    output fst_pkg::fst_status_t         status,
    input  logic [fst_pkg::ADDR_W-1:0]   s_source_address,
    input  logic [fst_pkg::PORT_W-1:0]   s_source_port,
    input  logic [fst_pkg::SIZE_W-1:0]   s_payload_size,
    input  logic [fst_pkg::TIME_W-1:0]   s_arrival_time,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fst_pkg::INDEX_W-1:0]  m_flow_index,
    output logic                         m_new_flow,
    output logic                         m_table_full,
    output logic [fst_pkg::BYTES_W-1:0]  m_flow_byte_total,
    output logic [fst_pkg::PKTS_W-1:0]   m_flow_packet_total,
    output logic [fst_pkg::TIME_W-1:0]   m_flow_first_seen,
    output logic [fst_pkg::TIME_W-1:0]   m_flow_last_seen,
    output logic [fst_pkg::COUNT_W-1:0]  m_active_flow_count,
    output logic [fst_pkg::BYTES_W-1:0]  m_all_flows_bytes
);
    import fst_pkg::*;

    localparam int IDX_W = $clog2(MAX_FLOWS);
    localparam int CNT_W = $clog2(MAX_FLOWS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FLOWS);

    logic [KEY_W-1:0] key_mem [MAX_FLOWS];
    fst_rec_t         rec_mem [MAX_FLOWS];

    logic [KEY_W-1:0]   key_in_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [KEY_W-1:0]   key_rd_reg;
    fst_rec_t           rec_rd_reg;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_valid_reg;
    logic               done_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [BYTES_W-1:0] grand_reg;
    logic               m_valid_reg;

    logic               cmp_match;
    logic               scan_step;
    logic               scan_more;
    logic               full;
    logic               create;
    logic [IDX_W-1:0]   used_idx;
    logic [IDX_W-1:0]   wr_slot;
    logic [BYTES_W:0]   flow_sum;
    logic [BYTES_W:0]   grand_sum;
    logic [BYTES_W-1:0] flow_bytes_sat;
    fst_rec_t           rec_new;
    logic [CNT_W-1:0]   used_next;
    logic [BYTES_W-1:0] grand_next;

    assign cmp_match = cmp_valid_reg && (key_rd_reg == key_in_reg);
    assign scan_step = cmd.scan && !done_reg;
    assign scan_more = scan_cnt_reg < used_reg;
    assign full      = !hit_reg && (used_reg == MAX_CNT);
    assign create    = !hit_reg && !full;
    assign used_idx  = used_reg[IDX_W-1:0];
    assign wr_slot   = hit_reg ? slot_reg : used_idx;

    always_comb begin
        flow_sum       = {1'b0, rec_rd_reg.bytes} + (BYTES_W + 1)'(size_reg);
        grand_sum      = {1'b0, grand_reg} + (BYTES_W + 1)'(size_reg);
        flow_bytes_sat = flow_sum[BYTES_W] ? '1 : flow_sum[BYTES_W-1:0];
        if (hit_reg) begin
            rec_new.bytes   = flow_bytes_sat;
            rec_new.packets = (rec_rd_reg.packets == '1) ? rec_rd_reg.packets
                                                         : rec_rd_reg.packets + 1'b1;
            rec_new.first   = rec_rd_reg.first;
            rec_new.last    = time_reg;
        end else begin
            rec_new.bytes   = BYTES_W'(size_reg);
            rec_new.packets = PKTS_W'(1);
            rec_new.first   = time_reg;
            rec_new.last    = time_reg;
        end
        used_next  = create ? used_reg + 1'b1 : used_reg;
        grand_next = full ? grand_reg : (grand_sum[BYTES_W] ? '1 : grand_sum[BYTES_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            grand_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.start) begin
                cmp_valid_reg <= 1'b0;
                done_reg      <= 1'b0;
                hit_reg       <= 1'b0;
            end else if (scan_step) begin
                if (cmp_match) begin
                    done_reg      <= 1'b1;
                    hit_reg       <= 1'b1;
                    cmp_valid_reg <= 1'b0;
                end else if (scan_more) begin
                    cmp_valid_reg <= 1'b1;
                end else begin
                    done_reg      <= 1'b1;
                    hit_reg       <= 1'b0;
                    cmp_valid_reg <= 1'b0;
                end
            end
            if (cmd.commit) begin
                used_reg    <= used_next;
                grand_reg   <= grand_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            key_in_reg   <= {s_source_address, s_source_port};
            size_reg     <= s_payload_size;
            time_reg     <= s_arrival_time;
            scan_cnt_reg <= '0;
        end else if (scan_step) begin
            if (cmp_match) begin
                slot_reg <= cmp_idx_reg;
            end else if (scan_more) begin
                cmp_idx_reg  <= scan_cnt_reg[IDX_W-1:0];
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
        if (cmd.commit) begin
            m_flow_index        <= full ? '0 : INDEX_W'(wr_slot);
            m_new_flow          <= create;
            m_table_full        <= full;
            m_flow_byte_total   <= full ? '0 : rec_new.bytes;
            m_flow_packet_total <= full ? '0 : rec_new.packets;
            m_flow_first_seen   <= full ? '0 : rec_new.first;
            m_flow_last_seen    <= full ? '0 : rec_new.last;
            m_active_flow_count <= COUNT_W'(used_next);
            m_all_flows_bytes   <= grand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_step && !cmp_match && scan_more) begin
            key_rd_reg <= key_mem[scan_cnt_reg[IDX_W-1:0]];
        end
        if (cmd.commit && create) begin
            key_mem[used_idx] <= key_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rec_rd && hit_reg) begin
            rec_rd_reg <= rec_mem[slot_reg];
        end
        if (cmd.commit && !full) begin
            rec_mem[wr_slot] <= rec_new;
        end
    end

    assign m_valid            = m_valid_reg;
    assign status.search_done = done_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

`ifndef NO_ASSERTIONS
    assert property (@(posedge aclk) disable iff (!aresetn) used_reg <= MAX_CNT)
        else $error("Flow count exceeds the table size.");
    assert property (@(posedge aclk) disable iff (!aresetn) cmd.commit |=> m_valid_reg)
        else $error("Committed item did not present a result.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && hit_reg) |-> (CNT_W'(slot_reg) < used_reg))
        else $error("Matched slot lies beyond the recorded flows.");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (m_ready || !m_valid_reg))
        else $error("Result register overwritten before it was taken.");
`endif

endmodule

// ----- rtl/flow_statistics_table.sv -----
// Per-flow packet statistics table: one item in, one result out, after a sequential key search.
// The search compares k stored flow keys, k being the slot of the match plus one, or all
// recorded flows on a miss, at most MAX_FLOWS.
// One item is processed at a time; the search reads one stored key per cycle, and an item's
// result waits to be committed while the previous result has not been taken.
// Synchronous active-low reset clears the flow count and the all-flows byte total; the
// table memories need no clearing, as only slots below the flow count are ever read.
module flow_statistics_table #(
    parameter int MAX_FLOWS = fst_pkg::MAX_FLOWS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fst_pkg::ADDR_W-1:0]   s_source_address,
    input  logic [fst_pkg::PORT_W-1:0]   s_source_port,
    input  logic [fst_pkg::SIZE_W-1:0]   s_payload_size,
    input  logic [fst_pkg::TIME_W-1:0]   s_arrival_time,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fst_pkg::INDEX_W-1:0]  m_flow_index,
    output logic                         m_new_flow,
    output logic                         m_table_full,
    output logic [fst_pkg::BYTES_W-1:0]  m_flow_byte_total,
    output logic [fst_pkg::PKTS_W-1:0]   m_flow_packet_total,
    output logic [fst_pkg::TIME_W-1:0]   m_flow_first_seen,
    output logic [fst_pkg::TIME_W-1:0]   m_flow_last_seen,
    output logic [fst_pkg::COUNT_W-1:0]  m_active_flow_count,
    output logic [fst_pkg::BYTES_W-1:0]  m_all_flows_bytes
);
    import fst_pkg::*;

    fst_cmd_t    cmd;
    fst_status_t status;

    fst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fst_datapath #(
        .MAX_FLOWS (MAX_FLOWS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .s_source_address    (s_source_address),
        .s_source_port       (s_source_port),
        .s_payload_size      (s_payload_size),
        .s_arrival_time      (s_arrival_time),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_flow_index        (m_flow_index),
        .m_new_flow          (m_new_flow),
        .m_table_full        (m_table_full),
        .m_flow_byte_total   (m_flow_byte_total),
        .m_flow_packet_total (m_flow_packet_total),
        .m_flow_first_seen   (m_flow_first_seen),
        .m_flow_last_seen    (m_flow_last_seen),
        .m_active_flow_count (m_active_flow_count),
        .m_all_flows_bytes   (m_all_flows_bytes)
    );

endmodule

// ----- tb/sv/flow_statistics_table_tb.sv -----
// Self-checking testbench for the per-flow datagram statistics table.
module flow_statistics_table_tb;
    import fst_pkg::*;

    localparam int TABLE_DEPTH = MAX_FLOWS_DEFAULT;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;

    typedef struct packed {
        logic [INDEX_W-1:0] slot;
        logic               created;
        logic               dropped;
        logic [BYTES_W-1:0] byte_total;
        logic [PKTS_W-1:0]  packet_total;
        logic [TIME_W-1:0]  first_seen;
        logic [TIME_W-1:0]  last_seen;
        logic [COUNT_W-1:0] active_count;
        logic [BYTES_W-1:0] all_bytes;
    } flow_report_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ADDR_W-1:0]   s_source_address;
    logic [PORT_W-1:0]   s_source_port;
    logic [SIZE_W-1:0]   s_payload_size;
    logic [TIME_W-1:0]   s_arrival_time;
    logic                m_valid;
    logic                m_ready;
    logic [INDEX_W-1:0]  m_flow_index;
    logic                m_new_flow;
    logic                m_table_full;
    logic [BYTES_W-1:0]  m_flow_byte_total;
    logic [PKTS_W-1:0]   m_flow_packet_total;
    logic [TIME_W-1:0]   m_flow_first_seen;
    logic [TIME_W-1:0]   m_flow_last_seen;
    logic [COUNT_W-1:0]  m_active_flow_count;
    logic [BYTES_W-1:0]  m_all_flows_bytes;

    logic [ADDR_W-1:0]  tbl_addr    [TABLE_DEPTH];
    logic [PORT_W-1:0]  tbl_port    [TABLE_DEPTH];
    logic [BYTES_W-1:0] tbl_bytes   [TABLE_DEPTH];
    logic [PKTS_W-1:0]  tbl_packets [TABLE_DEPTH];
    logic [TIME_W-1:0]  tbl_first   [TABLE_DEPTH];
    logic [TIME_W-1:0]  tbl_last    [TABLE_DEPTH];
    int                 flows_used = 0;
    logic [BYTES_W-1:0] grand_bytes = '0;

    flow_report_t pending_reports[$];
    int  fail_count = 0;
    int  reports_checked = 0;
    int  hit_count = 0;
    int  created_count = 0;
    int  dropped_count = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    logic [TIME_W-1:0] clock_us;

    flow_statistics_table dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_source_address    (s_source_address),
        .s_source_port       (s_source_port),
        .s_payload_size      (s_payload_size),
        .s_arrival_time      (s_arrival_time),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_flow_index        (m_flow_index),
        .m_new_flow          (m_new_flow),
        .m_table_full        (m_table_full),
        .m_flow_byte_total   (m_flow_byte_total),
        .m_flow_packet_total (m_flow_packet_total),
        .m_flow_first_seen   (m_flow_first_seen),
        .m_flow_last_seen    (m_flow_last_seen),
        .m_active_flow_count (m_active_flow_count),
        .m_all_flows_bytes   (m_all_flows_bytes)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [BYTES_W-1:0] sat_add64(input logic [BYTES_W-1:0] a,
                                                     input logic [BYTES_W-1:0] b);
        logic [BYTES_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
    endfunction

    function automatic flow_report_t predict_datagram(input logic [ADDR_W-1:0] addr,
                                                      input logic [PORT_W-1:0] port,
                                                      input logic [SIZE_W-1:0] size,
                                                      input logic [TIME_W-1:0] stamp);
        flow_report_t r;
        int slot;
        int i;
        r = '0;
        slot = -1;
        for (i = 0; i < flows_used; i++) begin
            if (slot < 0 && tbl_addr[i] == addr && tbl_port[i] == port) begin
                slot = i;
            end
        end
        if (slot >= 0) begin
            tbl_bytes[slot] = sat_add64(tbl_bytes[slot], BYTES_W'(size));
            if (tbl_packets[slot] != '1) begin
                tbl_packets[slot] = tbl_packets[slot] + 1'b1;
            end
            tbl_last[slot] = stamp;
            grand_bytes = sat_add64(grand_bytes, BYTES_W'(size));
            hit_count++;
        end else if (flows_used < TABLE_DEPTH) begin
            slot = flows_used;
            tbl_addr[slot] = addr;
            tbl_port[slot] = port;
            tbl_bytes[slot] = BYTES_W'(size);
            tbl_packets[slot] = 1;
            tbl_first[slot] = stamp;
            tbl_last[slot] = stamp;
            flows_used++;
            grand_bytes = sat_add64(grand_bytes, BYTES_W'(size));
            r.created = 1'b1;
            created_count++;
        end
        if (slot < 0) begin
            r.dropped = 1'b1;
            dropped_count++;
        end else begin
            r.slot = slot[INDEX_W-1:0];
            r.byte_total = tbl_bytes[slot];
            r.packet_total = tbl_packets[slot];
            r.first_seen = tbl_first[slot];
            r.last_seen = tbl_last[slot];
        end
        r.active_count = flows_used[COUNT_W-1:0];
        r.all_bytes = grand_bytes;
        return r;
    endfunction

    task automatic send_datagram(input logic [ADDR_W-1:0] addr, input logic [PORT_W-1:0] port,
                                 input logic [SIZE_W-1:0] size, input logic [TIME_W-1:0] stamp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_source_address <= addr;
        s_source_port <= port;
        s_payload_size <= size;
        s_arrival_time <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_reports.push_back(predict_datagram(addr, port, size, stamp));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        flow_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result item arrived with no item outstanding");
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("flow_index", 64'(want.slot), 64'(m_flow_index));
                check_field("new_flow", 64'(want.created), 64'(m_new_flow));
                check_field("table_full", 64'(want.dropped), 64'(m_table_full));
                check_field("flow_byte_total", want.byte_total, m_flow_byte_total);
                check_field("flow_packet_total", 64'(want.packet_total),
                            64'(m_flow_packet_total));
                check_field("flow_first_seen", want.first_seen, m_flow_first_seen);
                check_field("flow_last_seen", want.last_seen, m_flow_last_seen);
                check_field("active_flow_count", 64'(want.active_count),
                            64'(m_active_flow_count));
                check_field("all_flows_bytes", want.all_bytes, m_all_flows_bytes);
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Mostly packets on known flows, with fresh keys and keys that share only one half.
    task automatic send_traffic_item();
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] stamp;
        int pick;
        int slot;
        pick = $urandom_range(0, 99);
        addr = $urandom;
        port = PORT_W'($urandom);
        if (flows_used > 0 && pick < 85) begin
            slot = $urandom_range(0, flows_used - 1);
            addr = tbl_addr[slot];
            port = tbl_port[slot];
        end else if (flows_used > 0 && pick < 90) begin
            slot = $urandom_range(0, flows_used - 1);
            if (pick[0]) begin
                addr = tbl_addr[slot];
            end else begin
                port = tbl_port[slot];
            end
        end
        case ($urandom_range(0, 7))
            0: begin
                size = '0;
            end
            1: begin
                size = '1;
            end
            default: begin
                size = SIZE_W'($urandom);
            end
        endcase
        if ($urandom_range(0, 7) == 0) begin
            stamp = {$urandom, $urandom};
        end else begin
            clock_us = clock_us + TIME_W'($urandom_range(0, 5000));
            stamp = clock_us;
        end
        send_datagram(addr, port, size, stamp);
    endtask

    task automatic test_extremes();
        send_datagram('0, '0, '0, '0);
        send_datagram('1, '1, '1, '1);
        send_datagram('0, '0, '1, 64'd1);
        send_datagram('1, '1, '0, '0);
        send_datagram('0, '1, 16'd1, 64'd5);
        send_datagram('1, '0, 16'h8000, 64'h8000_0000_0000_0000);
        send_datagram(32'h8000_0000, 16'h8000, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_datagram(32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF);
        send_datagram(32'h5555_5555, 16'hAAAA, 16'hAAAA, 64'h5555_5555_5555_5555);
        send_datagram('0, '0, '1, '1);
        send_datagram('0, '0, '1, 64'd2);
        send_datagram(32'h8000_0000, 16'h8000, '0, '1);
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_traffic_item();
            if (n == count / 2) begin
                wait_drained();
            end
        end
    endtask

    task automatic test_table_full();
        while (flows_used < TABLE_DEPTH) begin
            send_datagram($urandom, PORT_W'($urandom), SIZE_W'($urandom),
                          {$urandom, $urandom});
        end
        send_datagram($urandom, PORT_W'($urandom), SIZE_W'($urandom), {$urandom, $urandom});
        send_datagram(tbl_addr[0], tbl_port[0] ^ 16'h1, '1, '1);
        send_datagram(tbl_addr[TABLE_DEPTH-1], tbl_port[TABLE_DEPTH-1], '1, '0);
        send_datagram(tbl_addr[0], tbl_port[0], '0, '1);
        send_datagram('1, 16'hFFFE, '1, '1);
        send_datagram(tbl_addr[TABLE_DEPTH-1] ^ 32'h8000_0000, tbl_port[TABLE_DEPTH-1],
                      16'h1234, 64'd42);
    endtask

    task automatic test_back_to_back(input int count);
        int n;
        wait_drained();
        idle_on = 1'b0;
        for (n = 0; n < count; n++) begin
            send_traffic_item();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_source_address = '0;
        s_source_port = '0;
        s_payload_size = '0;
        s_arrival_time = '0;
        clock_us = {$urandom, $urandom};
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_random_traffic(1300);
        test_table_full();
        test_back_to_back(280);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d results: %0d new flows, %0d packets on known flows, %0d dropped.",
                 reports_checked, created_count, hit_count, dropped_count);
        $display("Table filled to %0d flows, all-flows byte total 0x%0h.",
                 flows_used, grand_bytes);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
